@@ design/chd_pkg.sv @@
package chd_pkg;

  // Width of the chunk size / remaining byte counter
  localparam int unsigned SIZE_WIDTH = 24;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // Framing phase, one-hot
  typedef enum logic [7:0] {
    PH_FIRST   = 8'b0000_0001,
    PH_SIZE    = 8'b0000_0010,
    PH_SIZE_CR = 8'b0000_0100,
    PH_DATA    = 8'b0000_1000,
    PH_DATA_CR = 8'b0001_0000,
    PH_DATA_LF = 8'b0010_0000,
    PH_DONE    = 8'b0100_0000,
    PH_FAIL    = 8'b1000_0000
  } phase_e;

  typedef enum logic [1:0] {
    ST_COMPLETE = 2'd0,
    ST_PARTIAL  = 2'd1,
    ST_RAW      = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_beat_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic       is_last;
    status_e    status;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // ASCII hex digit decode
  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.val = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

@@ design/chd_in_if.sv @@
interface chd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

@@ design/chd_out_if.sv @@
interface chd_out_if;
  logic       valid;
  logic       ready;
  logic       data_valid;
  logic [7:0] data_byte;
  logic       is_last;
  logic [1:0] status;

  modport source (output valid, output data_valid, output data_byte, output is_last,
                  output status, input ready);
  modport sink   (input valid, input data_valid, input data_byte, input is_last,
                  input status, output ready);
endinterface

@@ design/chd_parse.sv @@
module chd_parse (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  chd_pkg::in_beat_t beat_i,
  output logic             has_result_o,
  output chd_pkg::result_t res_o
);
  import chd_pkg::*;

  phase_e                phase_q, phase_d;
  logic [SIZE_WIDTH-1:0] count_q, count_d;
  logic                  emitted_q, emitted_d;

  hex_t                  hex;
  logic [SIZE_WIDTH-1:0] base;
  logic [SIZE_WIDTH-1:0] shifted;
  logic [SIZE_WIDTH-1:0] cnt_dec;
  logic                  digit_ok;
  logic                  data_v;

  // One framing step for the current beat
  always_comb begin
    hex      = hex_decode(beat_i.in_byte);
    base     = (phase_q == PH_FIRST) ? '0 : count_q;
    digit_ok = hex.ok && (base[SIZE_WIDTH-1 -: 4] == 4'd0);
    shifted  = {base[SIZE_WIDTH-5:0], hex.val};
    cnt_dec  = count_q - 1'b1;

    phase_d   = phase_q;
    count_d   = count_q;
    emitted_d = emitted_q;
    data_v    = 1'b0;

    case (phase_q)
      PH_FIRST: begin
        count_d = shifted;
        phase_d = digit_ok ? PH_SIZE : PH_FAIL;
      end
      PH_SIZE: begin
        if (beat_i.in_byte == CHAR_CR) begin
          phase_d = PH_SIZE_CR;
        end else if (digit_ok) begin
          count_d = shifted;
        end else begin
          phase_d = PH_FAIL;
        end
      end
      PH_SIZE_CR: begin
        if (beat_i.in_byte != CHAR_LF) phase_d = PH_FAIL;
        else if (count_q == '0)        phase_d = PH_DONE;
        else                           phase_d = PH_DATA;
      end
      PH_DATA: begin
        data_v    = 1'b1;
        emitted_d = 1'b1;
        count_d   = cnt_dec;
        if (cnt_dec == '0) phase_d = PH_DATA_CR;
      end
      PH_DATA_CR: begin
        phase_d = (beat_i.in_byte == CHAR_CR) ? PH_DATA_LF : PH_FAIL;
      end
      PH_DATA_LF: begin
        if (beat_i.in_byte == CHAR_LF) begin
          phase_d = PH_SIZE;
          count_d = '0;
        end else begin
          phase_d = PH_FAIL;
        end
      end
      PH_DONE, PH_FAIL: begin
        phase_d = phase_q;
      end
      default: begin
        phase_d = PH_FAIL;
      end
    endcase

    // Result fields; status reflects the state after this beat
    res_o.data_valid = data_v;
    res_o.data_byte  = data_v ? beat_i.in_byte : 8'd0;
    res_o.is_last    = beat_i.in_last;
    if (!beat_i.in_last)        res_o.status = ST_COMPLETE;
    else if (phase_d == PH_DONE) res_o.status = ST_COMPLETE;
    else if (emitted_d)         res_o.status = ST_PARTIAL;
    else                        res_o.status = ST_RAW;
    has_result_o = data_v || beat_i.in_last;

    // End of body: start over for the next one
    if (beat_i.in_last) begin
      phase_d   = PH_FIRST;
      count_d   = '0;
      emitted_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_FIRST;
      count_q   <= '0;
      emitted_q <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      count_q   <= count_d;
      emitted_q <= emitted_d;
    end
  end

endmodule

@@ design/http_chunked_body_decoder.sv @@
// Chunked transfer body decoder. Raw body bytes enter on in_i, one per beat, with
// in_last on the final byte; decoded payload bytes leave on out_o, and the beat for
// the final input byte carries is_last and the status (complete, partial, use raw).
// Framing bytes give no output beat. Throughput is one byte per clock as long as
// out_o drains. The path is an input register followed by a single parse step that
// updates the framing state and loads the result register. The block is ready for
// a new body right after the beat holding is_last.
module http_chunked_body_decoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  chd_in_if.sink    in_i,
  chd_out_if.source out_o
);
  import chd_pkg::*;

  logic     s1_valid_q;
  in_beat_t s1_beat_q;
  logic     out_valid_q;
  result_t  out_res_q;

  logic     has_result;
  result_t  res;
  logic     out_free;
  logic     step;

  // Stage advance: parse beat moves on when it makes no output or output has room
  assign out_free   = !out_valid_q || out_o.ready;
  assign step       = s1_valid_q && (!has_result || out_free);
  assign in_i.ready = !s1_valid_q || step;

  chd_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .beat_i       (s1_beat_q),
    .has_result_o (has_result),
    .res_o        (res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_beat_q.in_byte <= in_i.in_byte;
      s1_beat_q.in_last <= in_i.in_last;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && has_result) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && has_result) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.data_valid = out_res_q.data_valid;
  assign out_o.data_byte  = out_res_q.data_byte;
  assign out_o.is_last    = out_res_q.is_last;
  assign out_o.status     = out_res_q.status;

endmodule

@@ design/chd_checker.sv @@
module chd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_data_valid_i,
  input logic [7:0] out_data_byte_i,
  input logic       out_is_last_i,
  input logic [1:0] out_status_i
);
  import chd_pkg::*;

  // Every output beat is payload or end of body
  a_beat_has_purpose: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_valid_i || out_is_last_i))
    else $error("output beat with neither payload nor last");

  // Status only reported on the last beat
  a_status_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_is_last_i) |-> (out_status_i == ST_COMPLETE))
    else $error("status set on non-last beat");

  // Framing-only beat carries a zero byte
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_data_valid_i) |-> (out_data_byte_i == 8'd0))
    else $error("non-payload beat with nonzero byte");

  // Status code is always a defined one
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_status_i == ST_COMPLETE || out_status_i == ST_PARTIAL ||
                     out_status_i == ST_RAW))
    else $error("undefined status code");

  // Payload on the last beat means status cannot be use raw
  a_payload_not_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_is_last_i && out_data_valid_i) |-> (out_status_i != ST_RAW))
    else $error("use raw status after emitting payload");

endmodule

bind http_chunked_body_decoder chd_checker u_chd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_data_valid_i (out_o.data_valid),
  .out_data_byte_i  (out_o.data_byte),
  .out_is_last_i    (out_o.is_last),
  .out_status_i     (out_o.status)
);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import chd_pkg::*;

  // Receiver stall patterns
  typedef enum int {
    RX_OPEN,
    RX_TOGGLE,
    RX_RANDOM,
    RX_HOLD
  } rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  chd_in_if  in_bus ();
  chd_out_if out_bus ();

  http_chunked_body_decoder uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #5 clk_i = ~clk_i;

  // Raw body bytes waiting for the driver, decoded beats waiting for the monitor
  in_beat_t   raw_bytes_q[$];
  result_t    decoded_q[$];
  logic [7:0] body_q[$];

  // Shadow of the framing state
  phase_e                fsm_phase;
  logic [SIZE_WIDTH-1:0] size_acc;
  logic                  emitted;

  int       err_count;
  int       burst_left;
  int       gap_left;
  in_beat_t drv_beat;
  rx_mode_e rx_mode;
  int       mode_left;
  int       hold_cnt;

  task automatic report(input string what);
    err_count++;
    if (err_count <= 40) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  // Shift one hex digit into the size; 0 on a non-hex char or overflow
  function automatic logic add_nibble(input logic [7:0] c);
    int v;
    v = nibble_of(c);
    if (v < 0) return 1'b0;
    if (size_acc[SIZE_WIDTH-1 -: 4] != 4'd0) return 1'b0;
    size_acc = {size_acc[SIZE_WIDTH-5:0], 4'(v)};
    return 1'b1;
  endfunction

  // Advance the framing state by one raw byte, queue the beat it causes
  task automatic decode_byte(input logic [7:0] b, input logic last);
    result_t r;
    logic    pass;
    pass = 1'b0;
    case (fsm_phase)
      PH_FIRST: begin
        size_acc  = '0;
        fsm_phase = add_nibble(b) ? PH_SIZE : PH_FAIL;
      end
      PH_SIZE: begin
        if (b == CHAR_CR) fsm_phase = PH_SIZE_CR;
        else if (!add_nibble(b)) fsm_phase = PH_FAIL;
      end
      PH_SIZE_CR: begin
        if (b != CHAR_LF) fsm_phase = PH_FAIL;
        else if (size_acc == '0) fsm_phase = PH_DONE;
        else fsm_phase = PH_DATA;
      end
      PH_DATA: begin
        pass     = 1'b1;
        emitted  = 1'b1;
        size_acc = size_acc - 1'b1;
        if (size_acc == '0) fsm_phase = PH_DATA_CR;
      end
      PH_DATA_CR: fsm_phase = (b == CHAR_CR) ? PH_DATA_LF : PH_FAIL;
      PH_DATA_LF: begin
        if (b == CHAR_LF) begin
          fsm_phase = PH_SIZE;
          size_acc  = '0;
        end else begin
          fsm_phase = PH_FAIL;
        end
      end
      default: ;
    endcase
    if (pass || last) begin
      r.data_valid = pass;
      r.data_byte  = pass ? b : 8'h00;
      r.is_last    = last;
      if (!last) r.status = ST_COMPLETE;
      else if (fsm_phase == PH_DONE) r.status = ST_COMPLETE;
      else r.status = emitted ? ST_PARTIAL : ST_RAW;
      decoded_q.insert(decoded_q.size(), r);
    end
    if (last) begin
      fsm_phase = PH_FIRST;
      size_acc  = '0;
      emitted   = 1'b0;
    end
  endtask

  // Body building helpers
  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) body_q.insert(body_q.size(), s[i]);
  endtask

  task automatic put_crlf();
    body_q.insert(body_q.size(), CHAR_CR);
    body_q.insert(body_q.size(), CHAR_LF);
  endtask

  // Hex size with random letter case and optional leading zeros
  task automatic put_size(input int unsigned v, input int zeros);
    logic [3:0]  nib[$];
    int unsigned t;
    logic [7:0]  c;
    t = v;
    do begin
      nib.push_front(t[3:0]);
      t = t >> 4;
    end while (t != 0);
    repeat (zeros) nib.push_front(4'd0);
    foreach (nib[i]) begin
      if (nib[i] < 4'd10) c = 8'h30 + 8'(nib[i]);
      else c = ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(nib[i]) - 8'd10;
      body_q.insert(body_q.size(), c);
    end
  endtask

  // Move the first keep bytes of the body to the driver queue, last flag on the final one
  task automatic close_body(input int keep);
    in_beat_t bt;
    for (int i = 0; i < keep; i++) begin
      bt.in_byte = body_q[i];
      bt.in_last = (i == keep - 1);
      raw_bytes_q.insert(raw_bytes_q.size(), bt);
    end
    body_q.delete();
  endtask

  task automatic random_body();
    int          kind;
    int          sz;
    int          cut;
    int unsigned wide;
    logic [7:0]  bad;
    kind = $urandom_range(99);
    // noise
    if (kind < 8) begin
      repeat ($urandom_range(6, 1)) body_q.insert(body_q.size(), 8'($urandom));
      close_body(body_q.size());
      return;
    end
    // very wide sizes, data always truncated
    if (kind < 14) begin
      wide = ($urandom_range(3) == 0) ? 32'h00FF_FFFF : ($urandom >> $urandom_range(12, 4));
      put_size(wide, 0);
      put_crlf();
      repeat ($urandom_range(6, 1)) body_q.insert(body_q.size(), 8'($urandom));
      close_body(body_q.size());
      return;
    end
    repeat ($urandom_range(4) == 0 ? 0 : $urandom_range(4, 1)) begin
      sz = ($urandom_range(5) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      put_size(sz, ($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0);
      put_crlf();
      repeat (sz) body_q.insert(body_q.size(), 8'($urandom));
      put_crlf();
    end
    // zero size line or empty line ends the body
    if ($urandom_range(1)) put_size(0, $urandom_range(1));
    put_crlf();
    repeat ($urandom_range(3)) body_q.insert(body_q.size(), 8'($urandom));
    // broken framing
    if (kind < 34) begin
      case ($urandom_range(3))
        0:       bad = CHAR_CR;
        1:       bad = CHAR_LF;
        2:       bad = "g";
        default: bad = 8'($urandom);
      endcase
      body_q[$urandom_range(body_q.size() - 1)] = bad;
    end
    cut = body_q.size();
    if ($urandom_range(9) < 2) cut = $urandom_range(body_q.size(), 1);
    close_body(cut);
  endtask

  // Driver: bursts of beats with random gaps, prediction on each accepted beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid   <= 1'b0;
      in_bus.in_byte <= 8'h00;
      in_bus.in_last <= 1'b0;
      fsm_phase  = PH_FIRST;
      size_acc   = '0;
      emitted    = 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) decode_byte(in_bus.in_byte, in_bus.in_last);
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_bus.valid <= 1'b0;
        end else if (raw_bytes_q.size() > 0) begin
          drv_beat = raw_bytes_q.pop_front();
          in_bus.valid   <= 1'b1;
          in_bus.in_byte <= drv_beat.in_byte;
          in_bus.in_last <= drv_beat.in_last;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(7) == 0) ? $urandom_range(300, 100)
                                                  : $urandom_range(24, 1);
            gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
          end
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure, switching between stall patterns
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      rx_mode   = RX_OPEN;
      mode_left = 0;
      hold_cnt  = 0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(3));
        mode_left = $urandom_range(150, 20);
      end
      mode_left--;
      case (rx_mode)
        RX_OPEN:   out_bus.ready <= 1'b1;
        RX_TOGGLE: out_bus.ready <= ~out_bus.ready;
        RX_RANDOM: out_bus.ready <= ($urandom_range(3) != 0);
        default: begin
          if (hold_cnt > 0) begin
            hold_cnt--;
            out_bus.ready <= 1'b0;
          end else begin
            out_bus.ready <= 1'b1;
            hold_cnt = $urandom_range(12, 1);
          end
        end
      endcase
    end
  end

  // Monitor: compare each output beat against the oldest prediction
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (decoded_q.size() == 0) begin
        report($sformatf("unexpected beat byte %02h last %0b", out_bus.data_byte,
                         out_bus.is_last));
      end else begin
        want = decoded_q.pop_front();
        if (out_bus.data_valid !== want.data_valid)
          report($sformatf("data_valid got %0b want %0b", out_bus.data_valid,
                           want.data_valid));
        if (out_bus.data_byte !== want.data_byte)
          report($sformatf("data_byte got %02h want %02h", out_bus.data_byte,
                           want.data_byte));
        if (out_bus.is_last !== want.is_last)
          report($sformatf("is_last got %0b want %0b", out_bus.is_last, want.is_last));
        if (out_bus.status !== 2'(want.status))
          report($sformatf("status got %0d want %0d", out_bus.status, want.status));
      end
    end
  end

  initial begin
    rst_ni    = 1'b0;
    err_count = 0;

    // zero size on the first line, then a swallowed trailing byte
    put_str("0"); put_crlf(); put_str("Z"); close_body(body_q.size());
    // first byte not hex
    put_str("G"); close_body(body_q.size());
    // one chunk, ended by an empty size line
    put_str("1"); put_crlf(); body_q.insert(body_q.size(), 8'hFF); put_crlf(); put_crlf();
    close_body(body_q.size());
    // truncated inside chunk data
    put_str("2"); put_crlf(); body_q.insert(body_q.size(), 8'h00);
    close_body(body_q.size());
    // CR in the size line not followed by LF
    put_str("1"); body_q.insert(body_q.size(), CHAR_CR); put_str("x");
    close_body(body_q.size());
    // missing CR LF after chunk data
    put_str("1"); put_crlf(); put_str("AB"); close_body(body_q.size());
    // size too wide for the counter
    put_str("1000000"); close_body(body_q.size());

    while (raw_bytes_q.size() < 830) random_body();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (raw_bytes_q.size() != 0 || in_bus.valid || decoded_q.size() != 0)
      @(negedge clk_i);
    repeat (20) @(posedge clk_i);

    if (decoded_q.size() != 0) report($sformatf("%0d beats never arrived", decoded_q.size()));
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
design/chd_pkg.sv
design/chd_in_if.sv
design/chd_out_if.sv
design/chd_parse.sv
design/http_chunked_body_decoder.sv
design/chd_checker.sv
verif/testbench.sv
